// ----- src/c_string_highlight_marker_macros.svh -----
// Assertion macros shared by the string highlight marker modules.
`ifndef C_STRING_HIGHLIGHT_MARKER_MACROS_SVH
`define C_STRING_HIGHLIGHT_MARKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge while reset is released.
`define CSHM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cshm assertion failed");

// Checked on every rising edge, reset included.
`define CSHM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cshm assertion failed");

`else

`define CSHM_ASSERT(lbl, clk, rst_n, prop)
`define CSHM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- src/cshm_pkg.sv -----
// Types, character codes and escape sequence tables of the string highlight marker.
`timescale 1ns / 1ps
`default_nettype none

package cshm_pkg;

    // Character codes used by the classifier and the sequencer.
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_LOWER_M  = 8'h6D;

    // Escape sequence lengths and the width of the position counter.
    localparam int RED_LEN   = 5;
    localparam int RESET_LEN = 4;
    localparam int IDX_W     = 3;

    typedef logic [IDX_W-1:0] seq_idx_t;

    // What a string quote does to the output.
    typedef enum logic [1:0] {
        Q_NONE,
        Q_OPEN,
        Q_CLOSE
    } quote_kind_t;

    // One classified input byte, as the front end hands it to the back end.
    typedef struct packed {
        logic [7:0]  text_byte;
        quote_kind_t quote;
        logic        tail_reset;
    } cmd_t;

    // Output sequencer phases.
    typedef enum logic [1:0] {
        PH_RED,
        PH_BYTE,
        PH_CLOSE,
        PH_TAIL
    } phase_t;

    // ESC [ 9 1 m
    function automatic logic [7:0] red_seq_byte(input seq_idx_t idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CH_ESC;
            3'd1:    b = CH_LBRACKET;
            3'd2:    b = CH_NINE;
            3'd3:    b = CH_ONE;
            default: b = CH_LOWER_M;
        endcase
        return b;
    endfunction

    // ESC [ 0 m
    function automatic logic [7:0] reset_seq_byte(input seq_idx_t idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CH_ESC;
            3'd1:    b = CH_LBRACKET;
            3'd2:    b = CH_ZERO;
            default: b = CH_LOWER_M;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- src/c_string_highlight_marker.sv -----
// Top level of the C string highlight marker: front end, command queue and back end.
`timescale 1ns / 1ps
`default_nettype none

// Highlights double-quoted strings in a stream of C source text. Each transaction on
// the s_ side carries one text byte and a flag on the last byte of a line; every byte
// comes out unchanged on the m_ side, with ESC[91m inserted before an opening quote and
// ESC[0m after a closing one, plus ESC[0m after each line that is not a whole-line
// comment. One input transaction yields between one and ten output transactions, and
// m_last_of_run marks the last of them. The block accepts one byte per cycle as long
// as every byte yields one output byte and m_ready stays high. A byte that brings
// escape bytes holds the back-end sequencer for all of its output bytes (up to ten),
// which it emits one per cycle while m_ready is high; meanwhile the front end keeps
// accepting bytes until the command queue of QUEUE_DEPTH entries fills. The accepting
// edge writes a transaction into the queue, and the back end loads it from there at an
// edge where it is idle or done with the last output byte of the previous one. Reset is
// synchronous and active low, and the block is ready right after it.
module c_string_highlight_marker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_text_byte,
    input  wire logic       s_line_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);

    // Classified bytes travel from the front end to the back end through the queue.
    cshm_pkg::cmd_t front_cmd;
    cshm_pkg::cmd_t queue_cmd;
    logic           front_push;
    logic           queue_full;
    logic           queue_pop;
    logic           queue_not_empty;

    // The front end tracks comment and string state and decides what to insert.
    cshm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .s_line_end  (s_line_end),
        .q_push      (front_push),
        .q_cmd       (front_cmd),
        .q_full      (queue_full)
    );

    // The queue lets the front end run ahead while escape bytes drain.
    cshm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_cmd),
        .not_empty (queue_not_empty)
    );

    // The back end holds the current output byte in registers and steps through it.
    cshm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (queue_not_empty),
        .q_cmd         (queue_cmd),
        .q_pop         (queue_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

// ----- src/cshm_front.sv -----
// Front end: accepts text bytes, tracks comment and string state, classifies each byte.
`timescale 1ns / 1ps
`default_nettype none
`include "c_string_highlight_marker_macros.svh"

module cshm_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_text_byte,
    input  wire logic           s_line_end,
    output logic                q_push,
    output cshm_pkg::cmd_t      q_cmd,
    input  wire logic           q_full
);

    logic       in_block_comment_reg, in_block_comment_next;
    logic       in_string_literal_reg, in_string_literal_next;
    logic       in_line_comment_reg, in_line_comment_next;
    logic       whole_line_comment_reg, whole_line_comment_next;
    logic       blank_prefix_reg, blank_prefix_next;
    logic [7:0] previous_byte_reg, previous_byte_next;
    logic       pair_opener_pending_reg, pair_opener_pending_next;

    logic                  blank;
    logic                  accept;
    cshm_pkg::quote_kind_t quote;
    logic                  tail_reset;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        blank = (s_text_byte == cshm_pkg::CH_SPACE) || (s_text_byte == cshm_pkg::CH_TAB);
        in_block_comment_next    = in_block_comment_reg;
        in_string_literal_next   = in_string_literal_reg;
        in_line_comment_next     = in_line_comment_reg;
        whole_line_comment_next  = whole_line_comment_reg;
        blank_prefix_next        = blank_prefix_reg;
        previous_byte_next       = s_text_byte;
        pair_opener_pending_next = pair_opener_pending_reg;
        quote                    = cshm_pkg::Q_NONE;

        // Leading blanks followed by two slashes make the whole line a comment.
        if (!whole_line_comment_reg && blank_prefix_reg) begin
            if (previous_byte_reg == cshm_pkg::CH_SLASH) begin
                if (s_text_byte == cshm_pkg::CH_SLASH) begin
                    whole_line_comment_next = 1'b1;
                end
                blank_prefix_next = 1'b0;
            end else if (!blank && s_text_byte != cshm_pkg::CH_SLASH) begin
                blank_prefix_next = 1'b0;
            end
        end

        if (!(whole_line_comment_next || in_line_comment_reg)) begin
            if (in_block_comment_reg) begin
                if (pair_opener_pending_reg && s_text_byte == cshm_pkg::CH_SLASH) begin
                    in_block_comment_next    = 1'b0;
                    pair_opener_pending_next = 1'b0;
                end else begin
                    pair_opener_pending_next = (s_text_byte == cshm_pkg::CH_STAR);
                end
            end else if (pair_opener_pending_reg && s_text_byte == cshm_pkg::CH_STAR) begin
                in_block_comment_next    = 1'b1;
                pair_opener_pending_next = 1'b0;
            end else if (pair_opener_pending_reg && s_text_byte == cshm_pkg::CH_SLASH) begin
                in_line_comment_next     = 1'b1;
                pair_opener_pending_next = 1'b0;
            end else if (s_text_byte == cshm_pkg::CH_QUOTE &&
                         previous_byte_reg != cshm_pkg::CH_BSLASH) begin
                if (!in_string_literal_reg) begin
                    quote                  = cshm_pkg::Q_OPEN;
                    in_string_literal_next = 1'b1;
                end else begin
                    quote                  = cshm_pkg::Q_CLOSE;
                    in_string_literal_next = 1'b0;
                end
                pair_opener_pending_next = 1'b0;
            end else begin
                pair_opener_pending_next = (s_text_byte == cshm_pkg::CH_SLASH);
            end
        end

        tail_reset = s_line_end && !whole_line_comment_next;

        // Per-line state starts over after the last byte of a line.
        if (s_line_end) begin
            in_string_literal_next   = 1'b0;
            in_line_comment_next     = 1'b0;
            whole_line_comment_next  = 1'b0;
            blank_prefix_next        = 1'b1;
            previous_byte_next       = 8'h00;
            pair_opener_pending_next = 1'b0;
        end

        q_cmd.text_byte  = s_text_byte;
        q_cmd.quote      = quote;
        q_cmd.tail_reset = tail_reset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_block_comment_reg    <= 1'b0;
            in_string_literal_reg   <= 1'b0;
            in_line_comment_reg     <= 1'b0;
            whole_line_comment_reg  <= 1'b0;
            blank_prefix_reg        <= 1'b1;
            previous_byte_reg       <= 8'h00;
            pair_opener_pending_reg <= 1'b0;
        end else if (accept) begin
            in_block_comment_reg    <= in_block_comment_next;
            in_string_literal_reg   <= in_string_literal_next;
            in_line_comment_reg     <= in_line_comment_next;
            whole_line_comment_reg  <= whole_line_comment_next;
            blank_prefix_reg        <= blank_prefix_next;
            previous_byte_reg       <= previous_byte_next;
            pair_opener_pending_reg <= pair_opener_pending_next;
        end
    end

    // A whole comment line has by definition left its blank prefix.
    `CSHM_ASSERT(a_wlc_ends_prefix, aclk, aresetn, whole_line_comment_reg |-> !blank_prefix_reg)

endmodule

`default_nettype wire

// ----- src/cshm_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "c_string_highlight_marker_macros.svh"

module cshm_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire cshm_pkg::cmd_t push_data,
    output logic                full,
    input  wire logic           pop,
    output cshm_pkg::cmd_t      pop_data,
    output logic                not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cshm_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill level never passes the depth, and an empty queue has aligned pointers.
    `CSHM_ASSERT(a_count_in_range, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `CSHM_ASSERT(a_empty_aligned, aclk, aresetn, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

`default_nettype wire

// ----- src/cshm_back.sv -----
// Back end: expands each classified byte into output bytes, one per ready cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "c_string_highlight_marker_macros.svh"

module cshm_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire cshm_pkg::cmd_t q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_last_of_run
);

    logic                busy_reg, busy_next;
    cshm_pkg::phase_t    phase_reg, phase_next;
    cshm_pkg::seq_idx_t  idx_reg, idx_next;
    cshm_pkg::cmd_t      cmd_reg, cmd_next;

    logic fire;
    logic last;
    logic load;

    assign m_valid       = busy_reg;
    assign fire          = busy_reg && m_ready;
    assign m_last_of_run = last;

    always_comb begin
        // Output byte and end-of-run flag for the current position.
        unique case (phase_reg)
            cshm_pkg::PH_RED: begin
                m_out_byte = cshm_pkg::red_seq_byte(idx_reg);
                last       = 1'b0;
            end
            cshm_pkg::PH_BYTE: begin
                m_out_byte = cmd_reg.text_byte;
                last       = (cmd_reg.quote != cshm_pkg::Q_CLOSE) && !cmd_reg.tail_reset;
            end
            cshm_pkg::PH_CLOSE: begin
                m_out_byte = cshm_pkg::reset_seq_byte(idx_reg);
                last       = (idx_reg == cshm_pkg::IDX_W'(cshm_pkg::RESET_LEN - 1))
                             && !cmd_reg.tail_reset;
            end
            default: begin
                m_out_byte = cshm_pkg::reset_seq_byte(idx_reg);
                last       = (idx_reg == cshm_pkg::IDX_W'(cshm_pkg::RESET_LEN - 1));
            end
        endcase

        load       = q_valid && (!busy_reg || (fire && last));
        q_pop      = load;
        busy_next  = busy_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;

        if (load) begin
            busy_next  = 1'b1;
            cmd_next   = q_cmd;
            idx_next   = '0;
            phase_next = (q_cmd.quote == cshm_pkg::Q_OPEN) ? cshm_pkg::PH_RED
                                                            : cshm_pkg::PH_BYTE;
        end else if (fire && last) begin
            busy_next = 1'b0;
        end else if (fire) begin
            unique case (phase_reg)
                cshm_pkg::PH_RED: begin
                    if (idx_reg == cshm_pkg::IDX_W'(cshm_pkg::RED_LEN - 1)) begin
                        phase_next = cshm_pkg::PH_BYTE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                cshm_pkg::PH_BYTE: begin
                    phase_next = (cmd_reg.quote == cshm_pkg::Q_CLOSE) ? cshm_pkg::PH_CLOSE
                                                                       : cshm_pkg::PH_TAIL;
                    idx_next   = '0;
                end
                cshm_pkg::PH_CLOSE: begin
                    if (idx_reg == cshm_pkg::IDX_W'(cshm_pkg::RESET_LEN - 1)) begin
                        phase_next = cshm_pkg::PH_TAIL;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                default: begin
                    idx_next = idx_reg + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= cshm_pkg::PH_BYTE;
            idx_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

    // Color prefix only for an opening quote, closing reset only for a closing one.
    `CSHM_ASSERT(a_red_only_open, aclk, aresetn, (busy_reg && phase_reg == cshm_pkg::PH_RED) |-> (cmd_reg.quote == cshm_pkg::Q_OPEN))
    `CSHM_ASSERT(a_close_only_close, aclk, aresetn, (busy_reg && phase_reg == cshm_pkg::PH_CLOSE) |-> (cmd_reg.quote == cshm_pkg::Q_CLOSE))

endmodule

`default_nettype wire

// ----- tb/c_string_highlight_marker_tb.sv -----
// Self-checking testbench for the C string highlight marker, with bursty input and output stalls.
`timescale 1ns / 1ps

module c_string_highlight_marker_tb;

    // Number of random text bytes sent after the directed rows.
    localparam int RANDOM_ITEMS = 320;
    // Hard stop for the whole run, in clock cycles. The slowest legal run is
    // roughly 350 transactions times ten output bytes, stretched by receiver
    // stalls and the sender's gaps, so this leaves a wide margin.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles to wait after the last expected byte, to catch stray output.
    localparam int DRAIN_CYCLES = 20;

    // One expected output transaction.
    typedef struct packed {
        logic [7:0] chr;
        logic       last;
    } out_beat_t;

    // One directed row. When n_typed is not zero, the first n_typed bytes of
    // typed are the full expected output for that byte, written by hand.
    typedef struct packed {
        logic [7:0]      chr;
        logic            eol;
        logic [2:0]      n_typed;
        logic [0:5][7:0] typed;
    } text_row_t;

    // Receiver stall patterns, switched whenever rx_tick wraps to zero.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_BEAT
    } rx_mode_t;

    // Kinds of token the random line builder strings together.
    typedef enum logic [2:0] {
        TK_CODE,
        TK_STRING,
        TK_LINE_CMT,
        TK_BLOCK_OPEN,
        TK_BLOCK_CLOSE,
        TK_NOISE,
        TK_BLANK
    } token_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_text_byte;
    logic       s_line_end;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    c_string_highlight_marker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_line_end    (s_line_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    // Highlighter state as predicted by the testbench. The block comment flag
    // survives line ends; everything else is per line.
    logic       blk_cmt    = 1'b0;
    logic       in_str     = 1'b0;
    logic       in_lcmt    = 1'b0;
    logic       whole_lcmt = 1'b0;
    logic       lead_blank = 1'b1;
    logic [7:0] prev_chr   = 8'h00;
    logic       opener     = 1'b0;

    logic [7:0] pred_run[$];   // output bytes predicted for one input byte
    out_beat_t  exp_q[$];      // output transactions still to arrive
    int         typed_q[$];    // directed row index per driven byte, -1 if random
    text_row_t  dir_rows[$];
    logic [7:0] line_q[$];     // random line being built

    int         mismatches = 0;
    int         cycle_cnt  = 0;
    int         burst_left = 0;
    rx_mode_t   rx_mode    = RX_FREE;
    logic [5:0] rx_tick    = '0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ESC [ 0 m, used after a closing quote and at the end of a line.
    function automatic void push_reset_seq();
        pred_run.push_back(cshm_pkg::CH_ESC);
        pred_run.push_back(cshm_pkg::CH_LBRACKET);
        pred_run.push_back(cshm_pkg::CH_ZERO);
        pred_run.push_back(cshm_pkg::CH_LOWER_M);
    endfunction

    // Predicts the output bytes for one accepted text byte and advances the
    // predicted state. Precedence matters: whole-line and line comments swallow
    // everything, then block comments, then comment openers, then quotes.
    function automatic void mark_byte(input logic [7:0] b, input logic eol);
        logic blank;
        blank = (b == cshm_pkg::CH_SPACE) || (b == cshm_pkg::CH_TAB);

        // Track whether the line so far is blanks, optionally followed by a
        // first slash; a second slash right after it makes a whole comment line.
        if (!whole_lcmt && lead_blank) begin
            if (prev_chr == cshm_pkg::CH_SLASH) begin
                if (b == cshm_pkg::CH_SLASH)
                    whole_lcmt = 1'b1;
                lead_blank = 1'b0;
            end else if (!blank && b != cshm_pkg::CH_SLASH) begin
                lead_blank = 1'b0;
            end
        end

        if (whole_lcmt || in_lcmt) begin
            pred_run.push_back(b);
        end else if (blk_cmt) begin
            pred_run.push_back(b);
            if (opener && b == cshm_pkg::CH_SLASH) begin
                blk_cmt = 1'b0;
                opener  = 1'b0;
            end else begin
                opener = (b == cshm_pkg::CH_STAR);
            end
        end else if (opener && b == cshm_pkg::CH_STAR) begin
            // Opens a block comment even inside a string.
            pred_run.push_back(b);
            blk_cmt = 1'b1;
            opener  = 1'b0;
        end else if (opener && b == cshm_pkg::CH_SLASH) begin
            pred_run.push_back(b);
            in_lcmt = 1'b1;
            opener  = 1'b0;
        end else if (b == cshm_pkg::CH_QUOTE && prev_chr != cshm_pkg::CH_BSLASH) begin
            if (!in_str) begin
                pred_run.push_back(cshm_pkg::CH_ESC);
                pred_run.push_back(cshm_pkg::CH_LBRACKET);
                pred_run.push_back(cshm_pkg::CH_NINE);
                pred_run.push_back(cshm_pkg::CH_ONE);
                pred_run.push_back(cshm_pkg::CH_LOWER_M);
                pred_run.push_back(b);
                in_str = 1'b1;
            end else begin
                pred_run.push_back(b);
                push_reset_seq();
                in_str = 1'b0;
            end
            opener = 1'b0;
        end else begin
            pred_run.push_back(b);
            opener = (b == cshm_pkg::CH_SLASH);
        end

        prev_chr = b;

        if (eol) begin
            if (!whole_lcmt)
                push_reset_seq();
            in_str     = 1'b0;
            in_lcmt    = 1'b0;
            whole_lcmt = 1'b0;
            lead_blank = 1'b1;
            prev_chr   = 8'h00;
            opener     = 1'b0;
        end
    endfunction

    function automatic void report_mismatch(input string what, input out_beat_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) at cycle %0d: expected byte %02h last %0b, got byte %02h last %0b",
                     what, cycle_cnt, want.chr, want.last, m_out_byte, m_last_of_run);
    endfunction

    task automatic add_row(input logic [7:0] chr, input logic eol,
                           input logic [2:0] n_typed, input logic [0:5][7:0] typed);
        text_row_t row;
        row.chr     = chr;
        row.eol     = eol;
        row.n_typed = n_typed;
        row.typed   = typed;
        dir_rows.push_back(row);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    // Builds one line of C-like text: code, strings with escapes and comment
    // marks inside them, line and block comments, blanks and raw noise bytes.
    // About one line in six starts as a whole comment line.
    task automatic build_line();
        string  code_set;
        string  str_set;
        int     roll;
        token_t tok;
        code_set = "abz_09;(){}=+-*/\\ \t";
        str_set  = "ab /*\\\"%n";
        line_q.delete();
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(0, 2))
                line_q.push_back($urandom_range(0, 1) ? cshm_pkg::CH_SPACE : cshm_pkg::CH_TAB);
            put_text("//");
        end
        repeat ($urandom_range(1, 5)) begin
            roll = $urandom_range(0, 9);
            tok  = (roll < 3) ? TK_CODE :
                   (roll < 5) ? TK_STRING :
                   (roll == 5) ? TK_LINE_CMT :
                   (roll == 6) ? TK_BLOCK_OPEN :
                   (roll == 7) ? TK_BLOCK_CLOSE :
                   (roll == 8) ? TK_NOISE : TK_BLANK;
            case (tok)
                TK_CODE: begin
                    repeat ($urandom_range(1, 4))
                        line_q.push_back(code_set[$urandom_range(0, code_set.len() - 1)]);
                end
                TK_STRING: begin
                    line_q.push_back(cshm_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 5))
                        line_q.push_back(str_set[$urandom_range(0, str_set.len() - 1)]);
                    // Now and then the string is left open to the end of the line.
                    if ($urandom_range(0, 4) != 0)
                        line_q.push_back(cshm_pkg::CH_QUOTE);
                end
                TK_LINE_CMT:    put_text("//");
                TK_BLOCK_OPEN:  put_text("/*");
                TK_BLOCK_CLOSE: put_text("*/");
                TK_NOISE:       line_q.push_back(8'($urandom_range(0, 255)));
                default: begin
                    line_q.push_back($urandom_range(0, 1) ? cshm_pkg::CH_SPACE
                                                          : cshm_pkg::CH_TAB);
                end
            endcase
        end
    endtask

    // Drives one text byte and returns once it is accepted. The sender works in
    // bursts; between bursts valid drops for a random gap, and a gap of zero
    // lets two bursts run together with no idle cycle at all.
    task automatic send_byte(input logic [7:0] chr, input logic eol, input int row);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        typed_q.push_back(row);
        s_valid     <= 1'b1;
        s_text_byte <= chr;
        s_line_end  <= eol;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: m_ready follows one of four patterns, from never stalling to
    // mostly stalling, and the pattern is drawn anew whenever rx_tick wraps to zero.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 6'd1;
        if (rx_tick == '0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_FREE:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= (rx_tick[2:0] != 3'd5);
        endcase
    end

    // Monitor and scoreboard in one process, so that a byte accepted at an edge
    // always has its expectations queued before any output at that edge is
    // checked. All signals are read as they were just before the edge.
    always @(posedge aclk) begin
        out_beat_t want;
        int        row;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                row = (typed_q.size() != 0) ? typed_q.pop_front() : -1;
                pred_run.delete();
                mark_byte(s_text_byte, s_line_end);
                // Hand-written rows override the prediction but the predicted
                // state still moves on.
                if (row >= 0 && dir_rows[row].n_typed != 0) begin
                    pred_run.delete();
                    for (int k = 0; k < dir_rows[row].n_typed; k++)
                        pred_run.push_back(dir_rows[row].typed[k]);
                end
                foreach (pred_run[k]) begin
                    want.chr  = pred_run[k];
                    want.last = (k == pred_run.size() - 1);
                    exp_q.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                if (exp_q.size() == 0) begin
                    want = '0;
                    report_mismatch("no byte expected", want);
                end else begin
                    want = exp_q.pop_front();
                    if (m_out_byte !== want.chr || m_last_of_run !== want.last)
                        report_mismatch("wrong output", want);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout with %0d output bytes outstanding", exp_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int items_sent;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_text_byte = 8'h00;
        s_line_end  = 1'b0;
        items_sent  = 0;

        // Directed rows. Expected output is typed in only where it is obvious:
        // plain bytes and the extreme byte values right after reset, and a
        // string opening. Everything else goes through the predictor.
        add_row("a",   1'b0, 3'd1, {8'h61, 40'h0});
        add_row(8'h00, 1'b0, 3'd1, {8'h00, 40'h0});
        add_row(8'hFF, 1'b1, 3'd5, {8'hFF, cshm_pkg::CH_ESC, cshm_pkg::CH_LBRACKET,
                                    cshm_pkg::CH_ZERO, cshm_pkg::CH_LOWER_M, 8'h00});
        // A tab, then two slashes: a whole comment line, so the quote on it is
        // passed through untouched and the line gets no trailing reset.
        add_row(cshm_pkg::CH_TAB,   1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_SLASH, 1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_SLASH, 1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_QUOTE, 1'b1, 3'd0, '0);
        // Opening quote, then an escaped quote that does not count, then a
        // slash-star inside the string that still opens a block comment.
        add_row(cshm_pkg::CH_QUOTE, 1'b0, 3'd6, {cshm_pkg::CH_ESC, cshm_pkg::CH_LBRACKET,
                                                 cshm_pkg::CH_NINE, cshm_pkg::CH_ONE,
                                                 cshm_pkg::CH_LOWER_M, cshm_pkg::CH_QUOTE});
        add_row(cshm_pkg::CH_BSLASH, 1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_QUOTE,  1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_SLASH,  1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_STAR,   1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_QUOTE,  1'b1, 3'd0, '0);
        // The block comment carries over to the next line and closes there,
        // then a complete string and a line comment that hides a quote.
        add_row(cshm_pkg::CH_STAR,  1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_SLASH, 1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_QUOTE, 1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_QUOTE, 1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_SLASH, 1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_SLASH, 1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_QUOTE, 1'b1, 3'd0, '0);
        // A slash at a line end does not pair with a star on the next line.
        add_row(cshm_pkg::CH_SLASH, 1'b1, 3'd0, '0);
        add_row(cshm_pkg::CH_STAR,  1'b0, 3'd0, '0);
        // The star of an opening pair cannot also start the closing pair.
        add_row(cshm_pkg::CH_SLASH, 1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_STAR,  1'b0, 3'd0, '0);
        add_row(cshm_pkg::CH_SLASH, 1'b1, 3'd0, '0);
        // Star at a line end and slash at the next line start do not close.
        add_row(cshm_pkg::CH_STAR,  1'b1, 3'd0, '0);
        add_row(cshm_pkg::CH_SLASH, 1'b0, 3'd0, '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].chr, dir_rows[i].eol, i);

        // Random lines until enough bytes have gone in. The block comment left
        // open above is closed, or not, by the random text itself.
        while (items_sent < RANDOM_ITEMS) begin
            build_line();
            foreach (line_q[i]) begin
                send_byte(line_q[i], i == line_q.size() - 1, -1);
                items_sent++;
            end
        end
        s_valid <= 1'b0;

        // The last accepted byte may not have reached the scoreboard yet at this
        // edge, so its pending row index counts as outstanding too.
        while (exp_q.size() != 0 || typed_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && exp_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
